// ===== rtl/a32fd_pkg.sv =====
// Shared types and codes for the A32 instruction field decoder.
package a32fd_pkg;

    typedef enum logic [2:0] {
        CLS_INVALID  = 3'd0,
        CLS_DATAPROC = 3'd1,
        CLS_MULTIPLY = 3'd2,
        CLS_LDST     = 3'd3,
        CLS_MULTIPLE = 3'd4,
        CLS_BRANCH   = 3'd5,
        CLS_SVC      = 3'd6,
        CLS_COPROC   = 3'd7
    } t_class;

    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;

    localparam logic [5:0] MODE_IMM   = 6'h01;
    localparam logic [5:0] MODE_SHREG = 6'h02;

    localparam logic [31:0] PC_AHEAD = 32'd8;

    typedef struct packed {
        logic [31:0] instruction_word;
        logic [31:0] instr_address;
        logic        word_complete;
    } t_in_item;

    typedef struct packed {
        t_class      instr_class;
        logic [3:0]  operation;
        logic [3:0]  condition;
        logic        sets_flags;
        logic [3:0]  reg_d;
        logic [3:0]  reg_n;
        logic [3:0]  reg_m;
        logic [3:0]  reg_s;
        logic [31:0] operand_value;
        logic [1:0]  shift_type;
        logic [5:0]  shift_amount;
        logic [5:0]  mode_flags;
    } t_out_item;

endpackage

// ===== rtl/a32fd_decode.sv =====
// Combinational classification and field extraction of one A32 word.
module a32fd_decode (
    input  a32fd_pkg::t_in_item  i_item,
    output a32fd_pkg::t_out_item o_result
);

    logic [31:0]       w;
    a32fd_pkg::t_class cls;
    logic [5:0]        imm_shift;
    logic [63:0]       rot_wide;
    logic [31:0]       rot_val;
    logic [31:0]       ls_off;
    logic [31:0]       br_target;
    a32fd_pkg::t_out_item res;

    assign w = i_item.instruction_word;

    // lsr/asr #0 encode a shift by 32
    always_comb begin
        if (w[11:7] == 5'd0 && (w[6:5] == a32fd_pkg::SHIFT_LSR ||
                                w[6:5] == a32fd_pkg::SHIFT_ASR)) begin
            imm_shift = 6'd32;
        end else begin
            imm_shift = {1'b0, w[11:7]};
        end
    end

    assign rot_wide  = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
    assign rot_val   = rot_wide[31:0];
    assign ls_off    = w[23] ? {20'd0, w[11:0]} : (32'd0 - {20'd0, w[11:0]});
    assign br_target = i_item.instr_address + a32fd_pkg::PC_AHEAD
                     + {{6{w[23]}}, w[23:0], 2'b00};

    always_comb begin
        priority if (!i_item.word_complete) begin
            cls = a32fd_pkg::CLS_INVALID;
        end else if (w[27:26] == 2'b00) begin
            if (!w[25] && w[7:4] == 4'b1001) begin
                // bit23 clear with bit22 set is not a multiply
                if (w[27:24] == 4'd0 && !(!w[23] && w[22])) begin
                    cls = a32fd_pkg::CLS_MULTIPLY;
                end else begin
                    cls = a32fd_pkg::CLS_LDST;
                end
            end else begin
                cls = a32fd_pkg::CLS_DATAPROC;
            end
        end else if (w[27:26] == 2'b01) begin
            cls = a32fd_pkg::CLS_LDST;
        end else if (w[27:25] == 3'b100) begin
            cls = a32fd_pkg::CLS_MULTIPLE;
        end else if (w[27:25] == 3'b101) begin
            cls = a32fd_pkg::CLS_BRANCH;
        end else if (w[27:24] == 4'hF) begin
            cls = a32fd_pkg::CLS_SVC;
        end else begin
            cls = a32fd_pkg::CLS_COPROC;
        end
    end

    always_comb begin
        res = '0;
        res.instr_class = cls;
        if (cls != a32fd_pkg::CLS_INVALID) begin
            res.condition = w[31:28];
        end
        unique case (cls)
            a32fd_pkg::CLS_INVALID: begin
            end
            a32fd_pkg::CLS_DATAPROC: begin
                res.operation  = w[24:21];
                res.sets_flags = w[20];
                res.reg_n      = w[19:16];
                res.reg_d      = w[15:12];
                if (w[25]) begin
                    res.operand_value = rot_val;
                    res.mode_flags    = a32fd_pkg::MODE_IMM;
                end else if (w[4]) begin
                    res.reg_m      = w[3:0];
                    res.shift_type = w[6:5];
                    res.reg_s      = w[11:8];
                    res.mode_flags = a32fd_pkg::MODE_SHREG;
                end else begin
                    res.reg_m        = w[3:0];
                    res.shift_type   = w[6:5];
                    res.shift_amount = imm_shift;
                end
            end
            a32fd_pkg::CLS_MULTIPLY: begin
                // long forms: umull 2, umlal 3, smull 4, smlal 5
                res.operation  = w[23] ? {1'b0, w[22], ~w[22], w[21]}
                                       : {3'd0, w[21]};
                res.sets_flags = w[20];
                res.reg_d      = w[19:16];
                res.reg_n      = w[15:12];
                res.reg_s      = w[11:8];
                res.reg_m      = w[3:0];
            end
            a32fd_pkg::CLS_LDST: begin
                res.operation     = {2'd0, w[20], w[22]};
                res.reg_n         = w[19:16];
                res.reg_d         = w[15:12];
                res.operand_value = ls_off;
                res.mode_flags    = {1'b0, w[21], w[23], w[24], 1'b0, ~w[25]};
                if (w[25]) begin
                    res.reg_m        = w[3:0];
                    res.shift_type   = w[6:5];
                    res.shift_amount = imm_shift;
                end
            end
            a32fd_pkg::CLS_MULTIPLE: begin
                res.operation     = {1'b0, w[20], w[24], w[23]};
                res.reg_n         = w[19:16];
                res.operand_value = {16'd0, w[15:0]};
                res.mode_flags    = {w[22], w[21], w[23], w[24], 2'b00};
            end
            a32fd_pkg::CLS_BRANCH: begin
                res.operation     = {3'd0, w[24]};
                res.operand_value = br_target;
            end
            a32fd_pkg::CLS_SVC: begin
                res.operand_value = {8'd0, w[23:0]};
            end
            a32fd_pkg::CLS_COPROC: begin
            end
            default: begin
            end
        endcase
    end

    assign o_result = res;

endmodule

// ===== rtl/arm32_instruction_field_decoder.sv =====
// Top level: registered A32 instruction field decoder, one word per cycle.
//
// Usage:
//   Input channel: drive i_item (word, its address, completeness flag) and
//   raise start. A word is taken at every rising edge where start is high
//   and busy is low; busy never rises, so a word can be taken every cycle.
//   Result channel: o_valid pulses for one cycle with the decoded fields on
//   o_result. The receiver must take the result in that cycle.
// Path: an accepted word passes the input register, the decode logic and
//   the result register before it appears on o_result.
// Throughput: one word per cycle; each word is independent and there is
//   no state carried between words.
// Reset: synchronous, active low on i_rst_n; clears the valid pipeline so
//   no result appears until a new word is taken.
// Stall: the receiver has no back pressure path, so results are never held.
module arm32_instruction_field_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  a32fd_pkg::t_in_item  i_item,
    output logic                 busy,
    output logic                 o_valid,
    output a32fd_pkg::t_out_item o_result
);

    a32fd_pkg::t_in_item  r_in;
    logic                 r_in_valid;
    a32fd_pkg::t_out_item n_out;
    a32fd_pkg::t_out_item r_out;
    logic                 r_out_valid;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    a32fd_decode u_decode (
        .i_item   (r_in),
        .o_result (n_out)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted word did not produce a result two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result strobe without an accepted word");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.instr_class == a32fd_pkg::CLS_INVALID) |->
        (o_result.condition == 4'd0 && o_result.operand_value == 32'd0 &&
         o_result.mode_flags == 6'd0 && o_result.operation == 4'd0))
        else $error("invalid result carries nonzero fields");

    a_coproc_only_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.instr_class == a32fd_pkg::CLS_COPROC) |->
        (o_result.operand_value == 32'd0 && o_result.mode_flags == 6'd0 &&
         o_result.reg_n == 4'd0 && o_result.reg_d == 4'd0))
        else $error("coprocessor result carries extra fields");
`endif

endmodule

// ===== tb/sv/arm32_instruction_field_decoder_tb.sv =====
// Testbench for the A32 instruction field decoder: directed and random words
// checked against a field-level decode predictor.
module arm32_instruction_field_decoder_tb;
    import a32fd_pkg::*;

    localparam logic [3:0] OP_MUL   = 4'd0;
    localparam logic [3:0] OP_MLA   = 4'd1;
    localparam logic [3:0] OP_UMULL = 4'd2;
    localparam logic [3:0] OP_UMLAL = 4'd3;
    localparam logic [3:0] OP_SMULL = 4'd4;
    localparam logic [3:0] OP_SMLAL = 4'd5;
    localparam logic [3:0] OP_STR   = 4'd0;
    localparam logic [3:0] OP_STRB  = 4'd1;
    localparam logic [3:0] OP_LDR   = 4'd2;
    localparam logic [3:0] OP_LDRB  = 4'd3;
    localparam logic [3:0] OP_B     = 4'd0;
    localparam logic [3:0] OP_BL    = 4'd1;

    localparam logic [5:0] MODE_PRE  = 6'h04;
    localparam logic [5:0] MODE_UP   = 6'h08;
    localparam logic [5:0] MODE_WB   = 6'h10;
    localparam logic [5:0] MODE_PSR  = 6'h20;

    localparam logic [3:0] MUL_MARK       = 4'b1001;
    localparam logic [5:0] SHIFT_AMT_FULL = 6'd32;
    localparam int         RESULT_LATENCY = 2;
    localparam int         RANDOM_WORDS   = 1700;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    t_out_item pending_decodes[$];
    int        error_count = 0;
    int        max_gap = 6;

    arm32_instruction_field_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Register operand with an immediate shift; lsr/asr by 0 mean 32.
    function automatic t_out_item with_imm_shift(input logic [31:0] w, input t_out_item r);
        t_out_item o;
        o = r;
        o.reg_m = w[3:0];
        o.shift_type = w[6:5];
        o.shift_amount = {1'b0, w[11:7]};
        if (w[11:7] == 5'd0 && (w[6:5] == SHIFT_LSR || w[6:5] == SHIFT_ASR))
            o.shift_amount = SHIFT_AMT_FULL;
        return o;
    endfunction

    function automatic t_out_item decode_transfer(input logic [31:0] w, input t_out_item r);
        t_out_item o;
        o = r;
        o.instr_class = CLS_LDST;
        o.operation = w[20] ? (w[22] ? OP_LDRB : OP_LDR) : (w[22] ? OP_STRB : OP_STR);
        o.reg_n = w[19:16];
        o.reg_d = w[15:12];
        // offset magnitude is the low 12 bits in every form, negated when down
        o.operand_value = w[23] ? {20'd0, w[11:0]} : 32'd0 - {20'd0, w[11:0]};
        o.mode_flags = (w[24] ? MODE_PRE : 6'h0) | (w[23] ? MODE_UP : 6'h0)
                     | (w[21] ? MODE_WB : 6'h0);
        if (w[25])
            o = with_imm_shift(w, o);
        else
            o.mode_flags = o.mode_flags | MODE_IMM;
        return o;
    endfunction

    function automatic t_out_item decode_a32(input t_in_item it);
        t_out_item   r;
        logic [31:0] w;
        logic [31:0] offs;
        logic [63:0] dbl;
        r = '0;
        w = it.instruction_word;
        if (!it.word_complete)
            return r;
        r.condition = w[31:28];
        casez (w[27:25])
            3'b00?: begin
                if (!w[25] && w[7:4] == MUL_MARK) begin
                    // 23=0,22=1 is undefined as a multiply; falls to transfer
                    if (w[27:24] == 4'h0 && !(!w[23] && w[22])) begin
                        r.instr_class = CLS_MULTIPLY;
                        if (!w[23])
                            r.operation = w[21] ? OP_MLA : OP_MUL;
                        else if (!w[22])
                            r.operation = w[21] ? OP_UMLAL : OP_UMULL;
                        else
                            r.operation = w[21] ? OP_SMLAL : OP_SMULL;
                        r.sets_flags = w[20];
                        r.reg_d = w[19:16];
                        r.reg_n = w[15:12];
                        r.reg_s = w[11:8];
                        r.reg_m = w[3:0];
                    end else begin
                        r = decode_transfer(w, r);
                    end
                end else begin
                    r.instr_class = CLS_DATAPROC;
                    r.operation = w[24:21];
                    r.sets_flags = w[20];
                    r.reg_n = w[19:16];
                    r.reg_d = w[15:12];
                    if (w[25]) begin
                        dbl = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
                        r.operand_value = dbl[31:0];
                        r.mode_flags = MODE_IMM;
                    end else if (w[4]) begin
                        r.reg_m = w[3:0];
                        r.shift_type = w[6:5];
                        r.reg_s = w[11:8];
                        r.mode_flags = MODE_SHREG;
                    end else begin
                        r = with_imm_shift(w, r);
                    end
                end
            end
            3'b01?: r = decode_transfer(w, r);
            3'b100: begin
                r.instr_class = CLS_MULTIPLE;
                r.operation = {1'b0, w[20], w[24], w[23]};  // load*4 + da/ia/db/ib
                r.reg_n = w[19:16];
                r.operand_value = {16'd0, w[15:0]};
                r.mode_flags = (w[24] ? MODE_PRE : 6'h0) | (w[23] ? MODE_UP : 6'h0)
                             | (w[21] ? MODE_WB : 6'h0) | (w[22] ? MODE_PSR : 6'h0);
            end
            3'b101: begin
                r.instr_class = CLS_BRANCH;
                r.operation = w[24] ? OP_BL : OP_B;
                offs = {{8{w[23]}}, w[23:0]};
                r.operand_value = it.instr_address + PC_AHEAD + (offs << 2);
            end
            default: begin
                if (w[27:24] == 4'hF) begin
                    r.instr_class = CLS_SVC;
                    r.operand_value = {8'd0, w[23:0]};
                end else begin
                    r.instr_class = CLS_COPROC;
                end
            end
        endcase
        return r;
    endfunction

    // Entered and left at a falling edge; the word is queued once taken.
    task automatic issue_word(input logic [31:0] w, input logic [31:0] addr,
                              input logic complete);
        int       gap;
        t_in_item it;
        gap = $urandom_range(0, max_gap);
        it.instruction_word = w;
        it.instr_address = addr;
        it.word_complete = complete;
        if (gap > 0) begin
            start <= 1'b0;
            i_item <= t_in_item'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        pending_decodes = {pending_decodes, decode_a32(it)};
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_decodes.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_result);
                error_count++;
            end else begin
                exp_r = pending_decodes.pop_front();
                check_field("instr_class", 32'(exp_r.instr_class), 32'(o_result.instr_class));
                check_field("operation", 32'(exp_r.operation), 32'(o_result.operation));
                check_field("condition", 32'(exp_r.condition), 32'(o_result.condition));
                check_field("sets_flags", 32'(exp_r.sets_flags), 32'(o_result.sets_flags));
                check_field("reg_d", 32'(exp_r.reg_d), 32'(o_result.reg_d));
                check_field("reg_n", 32'(exp_r.reg_n), 32'(o_result.reg_n));
                check_field("reg_m", 32'(exp_r.reg_m), 32'(o_result.reg_m));
                check_field("reg_s", 32'(exp_r.reg_s), 32'(o_result.reg_s));
                check_field("operand_value", exp_r.operand_value, o_result.operand_value);
                check_field("shift_type", 32'(exp_r.shift_type), 32'(o_result.shift_type));
                check_field("shift_amount", 32'(exp_r.shift_amount),
                            32'(o_result.shift_amount));
                check_field("mode_flags", 32'(exp_r.mode_flags), 32'(o_result.mode_flags));
            end
        end
    end

    task automatic test_incomplete_word();
        issue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_dataproc_forms();
        issue_word(32'h0000_0000, $urandom, 1'b1);  // andeq r0,r0,r0 lsl #0
        issue_word(32'hE3A0_00FF, $urandom, 1'b1);  // imm, no rotate
        issue_word(32'hE3B1_0FFF, $urandom, 1'b1);  // imm, ror 30, S set
        issue_word(32'hE1A0_0020, $urandom, 1'b1);  // lsr #0 -> 32
        issue_word(32'hE1A0_0040, $urandom, 1'b1);  // asr #0 -> 32
        issue_word(32'hE1A0_0060, $urandom, 1'b1);  // ror #0 kept as 0
        issue_word(32'hE1A0_0F8E, $urandom, 1'b1);  // lsl #31
        issue_word(32'hE011_F3F2, $urandom, 1'b1);  // shift by register
    endtask

    task automatic test_multiply_forms();
        issue_word(32'hE000_0091, $urandom, 1'b1);  // mul
        issue_word(32'hE03F_FF9F, $urandom, 1'b1);  // mla, S
        issue_word(32'hE080_0091, $urandom, 1'b1);  // umull
        issue_word(32'hE0A0_0091, $urandom, 1'b1);  // umlal
        issue_word(32'hE0C0_0091, $urandom, 1'b1);  // smull
        issue_word(32'hE0F0_0091, $urandom, 1'b1);  // smlal, S
        issue_word(32'hE040_0091, $urandom, 1'b1);  // undefined multiply form
        issue_word(32'hE100_0091, $urandom, 1'b1);  // 1001 with bit 24 set
    endtask

    task automatic test_transfer_forms();
        issue_word(32'hE591_2FFF, $urandom, 1'b1);  // ldr up, max offset
        issue_word(32'hE550_2FFF, $urandom, 1'b1);  // ldrb down
        issue_word(32'hE7A1_2043, $urandom, 1'b1);  // str reg offset, wb, asr #0
        issue_word(32'hE8BD_00FF, $urandom, 1'b1);  // ldm ia, wb
        issue_word(32'hE96D_FFFF, $urandom, 1'b1);  // stm db, psr, wb
    endtask

    task automatic test_branch_and_call();
        issue_word(32'hEA80_0000, 32'h0000_0000, 1'b1);  // most negative offset
        issue_word(32'hEB7F_FFFF, 32'hFFFF_FFFC, 1'b1);  // bl, target wraps
        issue_word(32'hFFFF_FFFF, $urandom, 1'b1);       // call, max number
        issue_word(32'hEE00_0000, $urandom, 1'b1);       // coprocessor
    endtask

    task automatic test_random_words();
        logic [31:0] w;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0)
                max_gap = ($urandom_range(0, 2) == 0) ? 0 : 6;
            w = $urandom;
            case ($urandom_range(0, 9))
                0, 1: w[27:26] = 2'b00;
                2: begin
                    w[27:24] = 4'h0;
                    w[7:4] = MUL_MARK;
                end
                3: begin
                    w[27:25] = 3'b000;
                    w[7:4] = MUL_MARK;
                end
                4, 5: w[27:26] = 2'b01;
                6: w[27:25] = 3'b100;
                7: w[27:25] = 3'b101;
                8: w[27:25] = 3'b111;
                default: ;
            endcase
            issue_word(w, $urandom, $urandom_range(0, 9) != 0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_incomplete_word();
        test_dataproc_forms();
        test_multiply_forms();
        test_transfer_forms();
        test_branch_and_call();
        test_random_words();
        start <= 1'b0;
        while (pending_decodes.size() > 0)
            @(posedge i_clk);
        repeat (RESULT_LATENCY + 4) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
